// File: rtl/core/u8u16_pkg.sv
// u8u16_pkg: shared types, constants and helpers for the UTF-8 to UTF-16 decoder.
// No dependencies; used by u8u16_decode, u8u16_out_fifo and the decoder core.
package u8u16_pkg;

    localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
    localparam logic [15:0] HI_SURR     = 16'hD800;
    localparam logic [15:0] LO_SURR     = 16'hDC00;
    localparam logic [20:0] SUPP_BASE   = 21'h010000;
    localparam logic [20:0] MAX_CP      = 21'h10FFFF;
    localparam logic [20:0] MAX_1BYTE   = 21'h00007F;
    localparam logic [20:0] MAX_2BYTE   = 21'h0007FF;
    localparam logic [20:0] MAX_BMP     = 21'h00FFFF;
    localparam logic [7:0]  ASCII_CR    = 8'h0D;
    localparam logic [7:0]  ASCII_LF    = 8'h0A;
    localparam logic [7:0]  CONT_LO     = 8'h80;
    localparam logic [7:0]  CONT_HI     = 8'hBF;
    localparam logic [1:0]  MAX_RESULTS = 2'd2;
    localparam logic [2:0]  FIFO_ROOM   = 3'd2;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        is_replacement;
        logic        last_of_run;
        logic        stream_done;
    } result_t;

    typedef struct packed {
        logic [1:0]        n;
        result_t [1:0]     res;
    } push_t;

    function automatic push_t push_unit(push_t p, logic [15:0] u, logic rp);
        if (p.n < MAX_RESULTS)
        begin
            p.res[p.n[0]].code_unit      = u;
            p.res[p.n[0]].is_replacement = rp;
            p.res[p.n[0]].last_of_run    = 1'b0;
            p.res[p.n[0]].stream_done    = 1'b0;
            p.n = p.n + 2'd1;
        end
        return p;
    endfunction

endpackage

// File: rtl/core/u8u16_decode.sv
// u8u16_decode: sequence state and the per-byte decode into up to two code units.
// Depends on u8u16_pkg.
module u8u16_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          in_byte,
    input  logic                end_of_text,
    input  logic                collapse_crlf,
    output u8u16_pkg::push_t    push
);

    logic [20:0] acc_reg, acc_next;
    logic [1:0]  rem_reg, rem_next;
    logic [1:0]  len_reg, len_next;
    logic        crp_reg, crp_next;

    u8u16_pkg::push_t p;
    logic             do_decode;
    logic [20:0]      v;
    logic [20:0]      d;
    logic [20:0]      cont_bits;
    logic [1:0]       nm1;

    always_comb
    begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        len_next  = len_reg;
        crp_next  = crp_reg;
        p         = '0;
        do_decode = 1'b1;
        v         = '0;
        d         = '0;
        cont_bits = '0;
        nm1       = '0;

        if (crp_reg)
        begin
            crp_next = 1'b0;
            if (in_byte == u8u16_pkg::ASCII_LF)
            begin
                p = u8u16_pkg::push_unit(p, {8'h00, u8u16_pkg::ASCII_LF}, 1'b0);
                do_decode = 1'b0;
            end
            else
            begin
                p = u8u16_pkg::push_unit(p, {8'h00, u8u16_pkg::ASCII_CR}, 1'b0);
            end
        end

        if (do_decode)
        begin
            if (rem_reg != 2'd0)
            begin
                if (in_byte >= u8u16_pkg::CONT_LO && in_byte <= u8u16_pkg::CONT_HI)
                begin
                    case (rem_reg)
                        2'd1:    cont_bits = {15'b0, in_byte[5:0]};
                        2'd2:    cont_bits = {9'b0, in_byte[5:0], 6'b0};
                        default: cont_bits = {3'b0, in_byte[5:0], 12'b0};
                    endcase
                    acc_next = acc_reg | cont_bits;
                    rem_next = rem_reg - 2'd1;
                    if (rem_next == 2'd0)
                    begin
                        v = acc_next;
                        d = v - u8u16_pkg::SUPP_BASE;
                        case (len_reg)
                            2'd1:
                            begin
                                if (v <= u8u16_pkg::MAX_1BYTE)
                                    p = u8u16_pkg::push_unit(p, u8u16_pkg::REPL_UNIT, 1'b1);
                                else
                                    p = u8u16_pkg::push_unit(p, v[15:0], 1'b0);
                            end
                            2'd2:
                            begin
                                if (v <= u8u16_pkg::MAX_2BYTE)
                                    p = u8u16_pkg::push_unit(p, u8u16_pkg::REPL_UNIT, 1'b1);
                                else
                                    p = u8u16_pkg::push_unit(p, v[15:0], 1'b0);
                            end
                            default:
                            begin
                                if (v <= u8u16_pkg::MAX_BMP || v > u8u16_pkg::MAX_CP)
                                    p = u8u16_pkg::push_unit(p, u8u16_pkg::REPL_UNIT, 1'b1);
                                else
                                begin
                                    p = u8u16_pkg::push_unit(p,
                                        u8u16_pkg::HI_SURR + {6'b0, d[19:10]}, 1'b0);
                                    p = u8u16_pkg::push_unit(p,
                                        u8u16_pkg::LO_SURR + {6'b0, d[9:0]}, 1'b0);
                                end
                            end
                        endcase
                        acc_next = '0;
                        len_next = 2'd0;
                    end
                end
                else
                begin
                    p = u8u16_pkg::push_unit(p, u8u16_pkg::REPL_UNIT, 1'b1);
                    acc_next = '0;
                    rem_next = 2'd0;
                    len_next = 2'd0;
                end
            end
            else
            begin
                case (in_byte) inside
                    [8'h00:8'h7F]:
                    begin
                        if (in_byte == u8u16_pkg::ASCII_CR && collapse_crlf)
                            crp_next = 1'b1;
                        else
                            p = u8u16_pkg::push_unit(p, {8'h00, in_byte}, 1'b0);
                    end
                    [8'hC0:8'hDF]:
                    begin
                        acc_next = {10'b0, in_byte[4:0], 6'b0};
                        rem_next = 2'd1;
                        len_next = 2'd1;
                    end
                    [8'hE0:8'hEF]:
                    begin
                        acc_next = {5'b0, in_byte[3:0], 12'b0};
                        rem_next = 2'd2;
                        len_next = 2'd2;
                    end
                    [8'hF0:8'hF7]:
                    begin
                        acc_next = {in_byte[2:0], 18'b0};
                        rem_next = 2'd3;
                        len_next = 2'd3;
                    end
                    default:
                        p = u8u16_pkg::push_unit(p, u8u16_pkg::REPL_UNIT, 1'b1);
                endcase
            end
        end

        if (end_of_text)
        begin
            if (rem_next != 2'd0)
                p = u8u16_pkg::push_unit(p, u8u16_pkg::REPL_UNIT, 1'b1);
            if (crp_next)
                p = u8u16_pkg::push_unit(p, {8'h00, u8u16_pkg::ASCII_CR}, 1'b0);
            acc_next = '0;
            rem_next = 2'd0;
            len_next = 2'd0;
            crp_next = 1'b0;
        end

        if (p.n != 2'd0)
        begin
            nm1 = p.n - 2'd1;
            p.res[nm1[0]].last_of_run = 1'b1;
            p.res[nm1[0]].stream_done = end_of_text;
        end
    end

    assign push = p;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            rem_reg <= '0;
            len_reg <= '0;
            crp_reg <= 1'b0;
        end
        else if (fire)
        begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
            len_reg <= len_next;
            crp_reg <= crp_next;
        end
    end

endmodule

// File: rtl/core/u8u16_out_fifo.sv
// u8u16_out_fifo: four-entry result queue, up to two writes and one read per cycle.
// Depends on u8u16_pkg.
module u8u16_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_en,
    input  u8u16_pkg::push_t    push,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output u8u16_pkg::result_t  out_res
);

    u8u16_pkg::result_t [3:0] mem_reg;
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] n_in;
    logic       pop;

    assign n_in      = push_en ? push.n : 2'd0;
    assign out_valid = (count_reg != 3'd0);
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg <= u8u16_pkg::FIFO_ROOM);
    assign out_res   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + n_in;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, n_in} - {2'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (n_in != 2'd0)
            mem_reg[wr_ptr_reg] <= push.res[0];
        if (n_in == 2'd2)
            mem_reg[wr_ptr_reg + 2'd1] <= push.res[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/core/utf8_to_utf16_crlf_decoder_core.sv
// Decodes a UTF-8 byte stream (s_tdata[7:0], s_tlast = end of text) into UTF-16 code
// units, one byte transfer per cycle while the four-entry result queue has room; a byte
// waits in the stage-1 register until the queue has room, then its results enter the queue,
// whose head is presented. Each byte gives zero to two units; the output moves one unit
// per cycle while m_tready is high, so the sustained rate is one byte per cycle while bytes
// give at most one unit each and follows the unit count otherwise. Invalid input
// gives U+FFFD with m_tuser[0] set; cfg_wr_en/cfg_wr_data write collapse_crlf (reset 1).
// Depends on u8u16_pkg, u8u16_decode, u8u16_out_fifo.
module utf8_to_utf16_crlf_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] code_unit
    output logic        m_tlast,   // last_of_run
    output logic [1:0]  m_tuser    // [0] is_replacement, [1] stream_done
);

    logic       collapse_reg;
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_eot_reg;
    logic       room;
    logic       fire;

    u8u16_pkg::push_t   push;
    u8u16_pkg::result_t out_res;

    assign fire     = s1_valid_reg && room;
    assign s_tready = !s1_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collapse_reg <= 1'b1;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                collapse_reg <= cfg_wr_data;
            if (s_tready)
                s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_byte_reg <= s_tdata;
            s1_eot_reg  <= s_tlast;
        end
    end

    u8u16_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .in_byte       (s1_byte_reg),
        .end_of_text   (s1_eot_reg),
        .collapse_crlf (collapse_reg),
        .push          (push)
    );

    u8u16_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (fire),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = out_res.code_unit;
    assign m_tlast = out_res.last_of_run;
    assign m_tuser = {out_res.stream_done, out_res.is_replacement};

endmodule

// File: rtl/core/u8u16_checker.sv
// u8u16_checker: port-level assertions for the decoder core, bound to the top level.
// Depends on utf8_to_utf16_crlf_decoder_core ports only.
module u8u16_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled output transfer changed");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("stream_done without last_of_run");

    a_repl_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 16'hFFFD)
        else $error("replacement flag on a unit other than U+FFFD");

endmodule

bind utf8_to_utf16_crlf_decoder_core u8u16_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
